### src/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SBA_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBA_ASSERT(label, clk, rstn, prop, msg)
`define SBA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### src/sba_pkg.sv
// Shared types and codes for the slab allocator.
`default_nettype none
package sba_pkg;
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_SMALL = 3'd1;
    localparam logic [2:0] ST_NO_PAGE = 3'd2;
    localparam logic [2:0] ST_NULL = 3'd3;
    localparam logic [2:0] ST_BAD_FREE = 3'd4;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;
    localparam int SMALLEST_CHUNK = 32;
    localparam int ADDR_SPACE = 65536;
    typedef struct packed {
        logic [15:0] chunk_address;
        logic [2:0]  status;
        logic [2:0]  size_class;
        logic        page_released;
    } result_t;
endpackage
`default_nettype wire

### src/sba_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module sba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/small_block_slab_allocator.sv
// Top level of the segregated size-class slab allocator.
// Channel  Dir  tdata fields (low bit up)                     tuser
// s_axis   in   request_bytes[15:0], address[31:16]           opcode
// m_axis   out  chunk_address[15:0], status[18:16],           -
//               size_class[21:19], page_released[22], pad
// Each item runs through the read-modify-write sequencer around the free-stack RAM:
// an oversized request ends after S_DEC; a carve, a fresh page or a free that does
// not release a page also passes S_POPRD or S_FREECHK; a pop from the free stack
// adds S_POPWAIT for the RAM read. A free that releases a page scans its class stack
// entry by entry and moves the top entry over each entry of that page.
// Reset clears page and class valid bits and stack depths at once.
// A result waits in the output register; the next item is accepted meanwhile.
`default_nettype none
`include "assert_macros.svh"
module small_block_slab_allocator #(
    parameter int NUM_PAGES = 16,
    parameter int PAGE_BYTES = 4096,
    parameter int HEADER_BYTES = 24,
    parameter int CLASS_COUNT = 5,
    parameter int STACK_DEPTH = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // request_bytes, address
    input  wire logic        s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // chunk_address, status, size_class, page_released
);
    function automatic int ADDR_SPACE_PAGES();
        int n;
        n = sba_pkg::ADDR_SPACE / PAGE_BYTES;
        return (n < NUM_PAGES) ? n : NUM_PAGES;
    endfunction

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int DW = $clog2(STACK_DEPTH);
    localparam int DCW = DW + 1;
    localparam int OB = $clog2(PAGE_BYTES);
    localparam int OW = OB + 1;
    localparam int SA = $clog2(CLASS_COUNT * STACK_DEPTH);
    localparam int LW = OB - 4;
    localparam int MAXP = ADDR_SPACE_PAGES();

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_POPRD, S_POPWAIT, S_FREECHK, S_SCAN_RD, S_SCAN_CHK,
        S_SWAP_RD, S_SWAP_WR, S_DONE
    } state_t;
    state_t state_reg;

    logic [NUM_PAGES-1:0]   pin_use_reg;
    logic [2:0]             pclass_reg [NUM_PAGES];
    logic [LW-1:0]          plive_reg  [NUM_PAGES];
    logic [CLASS_COUNT-1:0] wvalid_reg;
    logic [PW-1:0]          wpage_reg  [CLASS_COUNT];
    logic [OW-1:0]          woff_reg   [CLASS_COUNT];
    logic [DCW-1:0]         depth_reg  [CLASS_COUNT];

    logic        op_reg;
    logic [15:0] req_reg, addr_reg;
    logic [CW-1:0] cls_reg;
    logic [15:0] page_reg;
    logic [DCW-1:0] idx_reg;
    logic [DCW-1:0] hold_reg;
    sba_pkg::result_t res_reg;
    sba_pkg::result_t out_res_reg;
    logic out_valid_reg;

    logic ram_we;
    logic [SA-1:0] ram_waddr, ram_raddr;
    logic [15:0] ram_wdata, ram_rdata;

    sba_ram #(.WIDTH(16), .DEPTH(CLASS_COUNT * STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    function automatic logic [SA-1:0] saddr(input logic [CW-1:0] c, input logic [DCW-1:0] d);
        logic [SA+DCW:0] t;
        t = (SA+DCW+1)'(c) * (SA+DCW+1)'(STACK_DEPTH) + (SA+DCW+1)'(d[DW-1:0]);
        return t[SA-1:0];
    endfunction

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {1'b0, out_res_reg.page_released, out_res_reg.size_class,
                           out_res_reg.status, out_res_reg.chunk_address};

    // Decode helpers
    logic [CW-1:0] req_cls;
    logic req_big;
    always_comb begin
        req_cls = CW'(CLASS_COUNT - 1);
        for (int c = CLASS_COUNT - 2; c >= 0; c--) begin
            if (32'(req_reg) <= (32'(sba_pkg::SMALLEST_CHUNK) << c)) begin
                req_cls = CW'(c);
            end
        end
        req_big = 32'(req_reg) > (32'(sba_pkg::SMALLEST_CHUNK) << (CLASS_COUNT - 1));
    end

    logic [31:0] csz;
    assign csz = 32'(sba_pkg::SMALLEST_CHUNK) << cls_reg;

    logic [PW-1:0] free_pg;
    logic free_found;
    always_comb begin
        free_pg = '0;
        free_found = 1'b0;
        for (int p = MAXP - 1; p >= 0; p--) begin
            if (!pin_use_reg[p]) begin
                free_pg = PW'(p);
                free_found = 1'b1;
            end
        end
    end

    logic [15:0] apage;
    logic [31:0] aoff;
    assign apage = 16'(32'(addr_reg) / PAGE_BYTES);
    assign aoff = 32'(addr_reg) % PAGE_BYTES;
    logic [PW-1:0] apg;
    assign apg = apage[PW-1:0];
    logic [2:0] fcls;
    assign fcls = pclass_reg[apg];
    logic [31:0] fsz;
    assign fsz = 32'(sba_pkg::SMALLEST_CHUNK) << fcls;
    logic [31:0] rel;
    assign rel = aoff - 32'(HEADER_BYTES);
    logic bad_free;
    assign bad_free = (32'(apage) >= NUM_PAGES) || !pin_use_reg[apg]
        || (32'(fcls) >= CLASS_COUNT) || (aoff < 32'(HEADER_BYTES))
        || ((rel & (fsz - 32'd1)) != 32'd0) || (aoff + fsz > 32'(PAGE_BYTES))
        || (plive_reg[apg] == '0);

    logic [15:0] rpage;
    assign rpage = 16'(32'(ram_rdata) / PAGE_BYTES);

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = saddr(cls_reg, depth_reg[cls_reg]);
        ram_wdata = addr_reg;
        ram_raddr = saddr(cls_reg, idx_reg);
        if (state_reg == S_SCAN_RD) begin
            ram_raddr = saddr(cls_reg, idx_reg - DCW'(1));
        end
        if (state_reg == S_FREECHK && !bad_free) begin
            ram_waddr = saddr(CW'(fcls), depth_reg[CW'(fcls)]);
            ram_we = !((plive_reg[apg] == LW'(1)) &&
                       !(wvalid_reg[CW'(fcls)] && wpage_reg[CW'(fcls)] == apg))
                     && (32'(depth_reg[CW'(fcls)]) < STACK_DEPTH) && (addr_reg != 16'd0);
        end else if (state_reg == S_SWAP_WR) begin
            ram_we = 1'b1;
            ram_waddr = saddr(cls_reg, idx_reg);
            ram_wdata = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            pin_use_reg <= '0;
            wvalid_reg <= '0;
            for (int c = 0; c < CLASS_COUNT; c++) depth_reg[c] <= '0;
        end else begin
            if (out_valid_reg && m_axis_tready && state_reg != S_DONE) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        op_reg <= s_axis_tuser;
                        req_reg <= s_axis_tdata[15:0];
                        addr_reg <= s_axis_tdata[31:16];
                        res_reg <= '0;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (op_reg == sba_pkg::OP_FREE) begin
                        state_reg <= S_FREECHK;
                    end else if (req_big) begin
                        res_reg.status <= sba_pkg::ST_NOT_SMALL;
                        state_reg <= S_DONE;
                    end else begin
                        cls_reg <= req_cls;
                        res_reg.size_class <= 3'(req_cls);
                        idx_reg <= depth_reg[req_cls] - DCW'(1);
                        state_reg <= S_POPRD;
                    end
                end
                S_POPRD: begin
                    if (depth_reg[cls_reg] != '0) begin
                        depth_reg[cls_reg] <= idx_reg;
                        state_reg <= S_POPWAIT;
                    end else if (wvalid_reg[cls_reg] &&
                                 32'(PAGE_BYTES) - 32'(woff_reg[cls_reg]) >= csz) begin
                        res_reg.chunk_address <= 16'(32'(wpage_reg[cls_reg]) * PAGE_BYTES
                                                     + 32'(woff_reg[cls_reg]));
                        plive_reg[wpage_reg[cls_reg]] <= plive_reg[wpage_reg[cls_reg]] + LW'(1);
                        woff_reg[cls_reg] <= woff_reg[cls_reg] + OW'(csz);
                        if (32'(PAGE_BYTES) - 32'(woff_reg[cls_reg]) - csz < csz)
                            wvalid_reg[cls_reg] <= 1'b0;
                        state_reg <= S_DONE;
                    end else if (32'(HEADER_BYTES) + csz > 32'(PAGE_BYTES) || !free_found) begin
                        res_reg.status <= sba_pkg::ST_NO_PAGE;
                        state_reg <= S_DONE;
                    end else begin
                        pin_use_reg[free_pg] <= 1'b1;
                        pclass_reg[free_pg] <= 3'(cls_reg);
                        plive_reg[free_pg] <= LW'(1);
                        wpage_reg[cls_reg] <= free_pg;
                        woff_reg[cls_reg] <= OW'(HEADER_BYTES) + OW'(csz);
                        wvalid_reg[cls_reg] <= !(32'(PAGE_BYTES) - 32'(HEADER_BYTES) - csz < csz);
                        res_reg.chunk_address <= 16'(32'(free_pg) * PAGE_BYTES + HEADER_BYTES);
                        state_reg <= S_DONE;
                    end
                end
                S_POPWAIT: begin
                    res_reg.chunk_address <= ram_rdata;
                    if (32'(rpage) < NUM_PAGES)
                        plive_reg[rpage[PW-1:0]] <= plive_reg[rpage[PW-1:0]] + LW'(1);
                    state_reg <= S_DONE;
                end
                S_FREECHK: begin
                    if (addr_reg == 16'd0) begin
                        res_reg.status <= sba_pkg::ST_NULL;
                        state_reg <= S_DONE;
                    end else if (bad_free) begin
                        res_reg.status <= sba_pkg::ST_BAD_FREE;
                        state_reg <= S_DONE;
                    end else begin
                        res_reg.size_class <= fcls;
                        cls_reg <= CW'(fcls);
                        page_reg <= apage;
                        plive_reg[apg] <= plive_reg[apg] - LW'(1);
                        if (ram_we) begin
                            depth_reg[CW'(fcls)] <= depth_reg[CW'(fcls)] + DCW'(1);
                            state_reg <= S_DONE;
                        end else if ((plive_reg[apg] == LW'(1)) &&
                                 !(wvalid_reg[CW'(fcls)] && wpage_reg[CW'(fcls)] == apg)) begin
                            pin_use_reg[apg] <= 1'b0;
                            res_reg.page_released <= 1'b1;
                            idx_reg <= depth_reg[CW'(fcls)];
                            state_reg <= S_SCAN_RD;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN_RD: begin
                    if (idx_reg == '0) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg - DCW'(1);
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (rpage == page_reg) begin
                        hold_reg <= idx_reg;
                        idx_reg <= depth_reg[cls_reg] - DCW'(1);
                        depth_reg[cls_reg] <= depth_reg[cls_reg] - DCW'(1);
                        state_reg <= S_SWAP_RD;
                    end else begin
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SWAP_RD: begin
                    idx_reg <= hold_reg;
                    state_reg <= S_SWAP_WR;
                end
                S_SWAP_WR: begin
                    state_reg <= S_SCAN_RD;
                end
                S_DONE: begin
                    if (!out_valid_reg || m_axis_tready) begin
                        out_valid_reg <= 1'b1;
                        out_res_reg <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SBA_ASSERT(a_ready_idle, aclk, aresetn, s_axis_tready |-> state_reg == S_IDLE, "ready outside idle")
    `SBA_ASSERT(a_out_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")
    `SBA_ASSERT(a_accept_dec, aclk, aresetn, (s_axis_tvalid && s_axis_tready) |=> state_reg == S_DEC, "accept lost")
endmodule
`default_nettype wire

### tb/sv/small_block_slab_allocator_tb.sv
// Self-checking stream testbench for the small-block slab allocator.
`timescale 1ns / 1ps
module small_block_slab_allocator_tb;

    localparam int NPAGES = 16;
    localparam int PBYTES = 4096;
    localparam int HBYTES = 24;
    localparam int NCLASS = 5;
    localparam int SDEPTH = 2048;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    small_block_slab_allocator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Allocator shadow state.
    bit          pg_used [NPAGES];
    logic [2:0]  pg_cls [NPAGES];
    int unsigned pg_live [NPAGES];
    bit          wk_valid [NCLASS];
    int unsigned wk_page [NCLASS];
    int unsigned wk_off [NCLASS];
    logic [15:0] stk [NCLASS][SDEPTH];
    int unsigned stk_used [NCLASS];

    sba_pkg::result_t pending_results[$];
    logic [15:0] live_chunks[$];
    int          errors = 0;
    int          n_alloc = 0, n_free = 0, n_release = 0, n_nopage = 0, n_got = 0;
    bit          quiet = 1'b0;
    bit          hold_rx = 1'b0;

    function automatic int unsigned csize(int unsigned c);
        return 32 << c;
    endfunction

    function automatic logic [15:0] carve_chunk(int unsigned c);
        int unsigned p;
        int unsigned a;
        p = wk_page[c];
        a = (p * PBYTES + wk_off[c]) & 16'hFFFF;
        pg_live[p]++;
        wk_off[c] += csize(c);
        if (PBYTES - wk_off[c] < csize(c))
            wk_valid[c] = 1'b0;
        return a[15:0];
    endfunction

    function automatic sba_pkg::result_t allocate_chunk(int unsigned req);
        sba_pkg::result_t r;
        int unsigned c;
        int unsigned a;
        r = '0;
        if (req > csize(NCLASS - 1)) begin
            r.status = sba_pkg::ST_NOT_SMALL;
            return r;
        end
        for (c = 0; c + 1 < NCLASS; c++)
            if (csize(c) >= req)
                break;
        r.size_class = c[2:0];
        r.status = sba_pkg::ST_OK;
        if (stk_used[c] > 0) begin
            stk_used[c]--;
            a = 32'(stk[c][stk_used[c]]);
            if (a / PBYTES < NPAGES)
                pg_live[a / PBYTES]++;
            r.chunk_address = a[15:0];
            return r;
        end
        if (wk_valid[c] && PBYTES - wk_off[c] >= csize(c)) begin
            r.chunk_address = carve_chunk(c);
            return r;
        end
        if (HBYTES + csize(c) > PBYTES) begin
            r.status = sba_pkg::ST_NO_PAGE;
            return r;
        end
        for (int p = 0; p < NPAGES; p++) begin
            if (p * PBYTES + PBYTES > sba_pkg::ADDR_SPACE)
                break;
            if (!pg_used[p]) begin
                pg_used[p] = 1'b1;
                pg_cls[p] = c[2:0];
                pg_live[p] = 0;
                wk_valid[c] = 1'b1;
                wk_page[c] = p;
                wk_off[c] = HBYTES;
                r.chunk_address = carve_chunk(c);
                return r;
            end
        end
        r.status = sba_pkg::ST_NO_PAGE;
        return r;
    endfunction

    function automatic sba_pkg::result_t free_chunk(int unsigned a);
        sba_pkg::result_t r;
        int unsigned p, off, sz, c, i, last;
        r = '0;
        if (a == 0) begin
            r.status = sba_pkg::ST_NULL;
            return r;
        end
        p = a / PBYTES;
        off = a % PBYTES;
        if (p >= NPAGES || !pg_used[p] || pg_cls[p] >= NCLASS) begin
            r.status = sba_pkg::ST_BAD_FREE;
            return r;
        end
        c = pg_cls[p];
        sz = csize(c);
        if (off < HBYTES || (off - HBYTES) % sz != 0 || off + sz > PBYTES
                || pg_live[p] == 0) begin
            r.status = sba_pkg::ST_BAD_FREE;
            return r;
        end
        r.status = sba_pkg::ST_OK;
        r.size_class = c[2:0];
        pg_live[p]--;
        if (pg_live[p] == 0 && !(wk_valid[c] && wk_page[c] == p)) begin
            i = stk_used[c];
            while (i > 0) begin
                i--;
                if (stk[c][i] / PBYTES == p) begin
                    last = stk_used[c] - 1;
                    stk[c][i] = stk[c][last];
                    stk_used[c] = last;
                end
            end
            pg_used[p] = 1'b0;
            r.page_released = 1'b1;
            return r;
        end
        if (stk_used[c] < SDEPTH) begin
            stk[c][stk_used[c]] = a[15:0];
            stk_used[c]++;
        end
        return r;
    endfunction

    task automatic send_item(logic op, logic [15:0] req, logic [15:0] addr);
        int gap;
        sba_pkg::result_t r;
        gap = 0;
        if (!quiet && $urandom_range(99) < 21)
            gap = $urandom_range(6, 1);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {addr, req};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        if (op == sba_pkg::OP_ALLOC) begin
            r = allocate_chunk(32'(req));
            n_alloc++;
            if (r.status == sba_pkg::ST_OK)
                live_chunks.push_back(r.chunk_address);
            if (r.status == sba_pkg::ST_NO_PAGE)
                n_nopage++;
        end else begin
            r = free_chunk(32'(addr));
            n_free++;
            if (r.page_released)
                n_release++;
        end
        pending_results.push_back(r);
    endtask

    task automatic free_live(int idx);
        logic [15:0] a;
        a = live_chunks[idx];
        live_chunks.delete(idx);
        send_item(sba_pkg::OP_FREE, 16'($urandom), a);
    endtask

    task automatic settle;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else if (hold_rx)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= quiet || ($urandom_range(99) >= 21);
    end

    always @(posedge aclk) begin
        sba_pkg::result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.chunk_address = m_axis_tdata[15:0];
            got.status = m_axis_tdata[18:16];
            got.size_class = m_axis_tdata[21:19];
            got.page_released = m_axis_tdata[22];
            n_got++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.chunk_address !== want.chunk_address) begin
                    $display("%0t: chunk_address expected %h actual %h",
                             $time, want.chunk_address, got.chunk_address);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.size_class !== want.size_class) begin
                    $display("%0t: size_class expected %0d actual %0d",
                             $time, want.size_class, got.size_class);
                    errors++;
                end
                if (got.page_released !== want.page_released) begin
                    $display("%0t: page_released expected %0d actual %0d",
                             $time, want.page_released, got.page_released);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed;
        send_item(sba_pkg::OP_ALLOC, 16'd0, 16'hFFFF);
        send_item(sba_pkg::OP_ALLOC, 16'd1, 16'd0);
        send_item(sba_pkg::OP_ALLOC, 16'd32, 16'd0);
        send_item(sba_pkg::OP_ALLOC, 16'd33, 16'd0);
        send_item(sba_pkg::OP_ALLOC, 16'd512, 16'd0);
        send_item(sba_pkg::OP_ALLOC, 16'd513, 16'd0);
        send_item(sba_pkg::OP_ALLOC, 16'hFFFF, 16'd0);
        send_item(sba_pkg::OP_FREE, 16'hFFFF, 16'd0);
        send_item(sba_pkg::OP_FREE, 16'd0, 16'hFFFF);
        send_item(sba_pkg::OP_FREE, 16'd0, 16'd8);
        send_item(sba_pkg::OP_FREE, 16'd0, 16'd40);
        send_item(sba_pkg::OP_FREE, 16'd0, 16'd4095);
        send_item(sba_pkg::OP_FREE, 16'd0, 16'h7018);
        free_live(0);
        send_item(sba_pkg::OP_FREE, 16'd0, 16'd24);
        send_item(sba_pkg::OP_ALLOC, 16'd20, 16'd0);
        while (live_chunks.size() > 0)
            free_live(live_chunks.size() - 1);
        settle();
    endtask

    task automatic test_page_exhaustion;
        repeat (NPAGES * 7 + 3)
            send_item(sba_pkg::OP_ALLOC, 16'd300, 16'd0);
        send_item(sba_pkg::OP_ALLOC, 16'd31, 16'd0);
        while (live_chunks.size() > 0)
            free_live($urandom_range(live_chunks.size() - 1));
        settle();
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_rx = 1'b1;
                repeat (400) @(posedge aclk);
                hold_rx = 1'b0;
            end
            repeat (30)
                send_item(sba_pkg::OP_ALLOC, 16'($urandom_range(600)), 16'd0);
        join
        settle();
    endtask

    task automatic test_random(int count);
        int k;
        logic [15:0] sz;
        for (int n = 0; n < count; n++) begin
            quiet = (n >= count / 3 && n < count / 2);
            k = $urandom_range(99);
            if (k < 50 || (k < 88 && live_chunks.size() == 0)) begin
                case ($urandom_range(3))
                    0: sz = 16'($urandom_range(64));
                    1: sz = 16'($urandom_range(256));
                    2: sz = 16'($urandom_range(512));
                    default: sz = 16'($urandom_range(65535, 480));
                endcase
                send_item(sba_pkg::OP_ALLOC, sz, 16'($urandom));
            end else if (k < 88) begin
                free_live($urandom_range(live_chunks.size() - 1));
            end else if (k < 94) begin
                send_item(sba_pkg::OP_FREE, 16'($urandom), 16'($urandom));
            end else if (k < 97) begin
                send_item(sba_pkg::OP_FREE, 16'($urandom), 16'd0);
            end else begin
                send_item(sba_pkg::OP_FREE, 16'($urandom),
                          16'(($urandom_range(15) << 12) + 24 + 32 * $urandom_range(120)));
            end
        end
        quiet = 1'b0;
        while (live_chunks.size() > 0)
            free_live($urandom_range(live_chunks.size() - 1));
        settle();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_page_exhaustion();
        test_backpressure();
        test_random(800);
        $display("Covered %0d allocates and %0d frees, %0d results checked.",
                 n_alloc, n_free, n_got);
        $display("Pages released %0d times, out-of-page seen %0d times.",
                 n_release, n_nopage);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

### filelist.f
+incdir+src
src/sba_pkg.sv
src/sba_ram.sv
src/small_block_slab_allocator.sv
tb/sv/small_block_slab_allocator_tb.sv
